/* design/hons_pkg.sv */
package hons_pkg;

   localparam int unsigned QW = 64;
   localparam int unsigned CSR_IDX_W = 4;
   localparam int unsigned CSR_DATA_W = 8;

   localparam logic [QW-1:0] ONE_Q   = 64'h0000_0001_0000_0000;
   localparam logic [QW-1:0] SIGN_Q  = 64'h8000_0000_0000_0000;
   localparam logic [QW-1:0] MAXP_Q  = 64'h7FFF_FFFF_FFFF_FFFF;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_DIVZ = 2'd1;
   localparam logic [1:0] ST_OVF  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_ORDER = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MODE  = 4'd1;

   typedef struct packed {
      logic [QW-1:0] val;
      logic [1:0]    err;
   } qres_type;

   function automatic logic [QW-1:0] mag(input logic [QW-1:0] v);
      return v[QW-1] ? (~v + 64'd1) : v;
   endfunction

   function automatic logic [1:0] note(input logic [1:0] cur, input logic [1:0] code);
      return (cur == ST_OK) ? code : cur;
   endfunction

   function automatic qres_type pack_q(input logic neg, input logic [QW-1:0] m,
                                       input logic ovf);
      logic [QW-1:0] lim;
      logic [QW-1:0] mm;
      qres_type      r;
      lim = neg ? SIGN_Q : MAXP_Q;
      mm  = m;
      r.err = ST_OK;
      if (ovf || (m > lim)) begin
         r.err = ST_OVF;
         mm    = lim;
      end
      r.val = neg ? (~mm + 64'd1) : mm;
      return r;
   endfunction

   function automatic qres_type q_neg(input logic [QW-1:0] v);
      qres_type r;
      r.err = ST_OK;
      r.val = ~v + 64'd1;
      if (v == SIGN_Q) begin
         r.err = ST_OVF;
         r.val = MAXP_Q;
      end
      return r;
   endfunction

   function automatic qres_type q_sub(input logic [QW-1:0] a, input logic [QW-1:0] b);
      logic [QW-1:0] d;
      qres_type      r;
      d     = a - b;
      r.err = ST_OK;
      r.val = d;
      if (((a[QW-1] ^ b[QW-1]) != 1'b0) && ((d[QW-1] ^ a[QW-1]) != 1'b0)) begin
         r.err = ST_OVF;
         r.val = a[QW-1] ? SIGN_Q : MAXP_Q;
      end
      return r;
   endfunction

endpackage

/* design/hons_if.sv */
interface hons_req_if import hons_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic signed [QW-1:0] derivative;
   modport source (output valid, output derivative, input ready);
   modport sink (input valid, input derivative, output ready);
endinterface

interface hons_rsp_if import hons_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic signed [QW-1:0] step;
   logic [1:0]           status;
   modport source (output valid, output step, output status, input ready);
   modport sink (input valid, input step, input status, output ready);
endinterface

interface hons_csr_if import hons_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

/* design/hons_mul.sv */
module hons_mul import hons_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [QW-1:0]   a,
   input  logic [QW-1:0]   b,
   output logic            done,
   output logic [2*QW-1:0] prod
);
   logic [QW-1:0]   a_ff, a_in, b_ff, b_in;
   logic [2*QW-1:0] acc_ff, acc_in;
   logic [1:0]      idx_ff, idx_in;
   logic            busy_ff, busy_in, done_ff, done_in;
   logic [31:0]     xa, yb;
   logic [63:0]     pp;
   logic [2*QW-1:0] pp_sh;

   always_comb begin
      xa = idx_ff[0] ? a_ff[63:32] : a_ff[31:0];
      yb = idx_ff[1] ? b_ff[63:32] : b_ff[31:0];
      pp = {32'd0, xa} * {32'd0, yb};
      case ({1'b0, idx_ff[0]} + {1'b0, idx_ff[1]})
         2'd0:    pp_sh = {64'd0, pp};
         2'd1:    pp_sh = {32'd0, pp, 32'd0};
         2'd2:    pp_sh = {pp, 64'd0};
         default: pp_sh = '0;
      endcase
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      idx_in  = idx_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = a;
         b_in    = b;
         acc_in  = '0;
         idx_in  = 2'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = acc_ff + pp_sh;
         idx_in = idx_ff + 2'd1;
         if (idx_ff == 2'd3) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      idx_ff <= idx_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign prod = acc_ff;
endmodule

/* design/hons_div.sv */
module hons_div import hons_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [QW+31:0]  num,
   input  logic [QW-1:0]   den,
   output logic            done,
   output logic [QW-1:0]   quo,
   output logic            ovf
);
   localparam int unsigned NBITS = QW + 32;

   logic [NBITS-1:0] num_ff, num_in;
   logic [QW-1:0]    den_ff, den_in, q_ff, q_in;
   logic [QW-1:0]    rem_ff, rem_in;
   logic [6:0]       cnt_ff, cnt_in;
   logic             ovf_ff, ovf_in, busy_ff, busy_in, done_ff, done_in;
   logic [QW:0]      r2;

   always_comb begin
      r2      = {rem_ff, num_ff[NBITS-1]};
      num_in  = num_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      ovf_in  = ovf_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = num;
         den_in  = den;
         q_in    = '0;
         rem_in  = '0;
         cnt_in  = 7'(NBITS - 1);
         ovf_in  = 1'b0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[NBITS-2:0], 1'b0};
         ovf_in = ovf_ff | q_ff[QW-1];
         if (r2 >= {1'b0, den_ff}) begin
            rem_in = QW'(r2 - {1'b0, den_ff});
            q_in   = {q_ff[QW-2:0], 1'b1};
         end else begin
            rem_in = r2[QW-1:0];
            q_in   = {q_ff[QW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      ovf_ff <= ovf_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quo  = q_ff;
   assign ovf  = ovf_ff;
endmodule

/* design/higher_order_newton_step.sv */
// Higher-order Newton step unit.
// req_if carries the derivative values f, f', f''... of one point, lowest order
// first, one transfer each. After order+1 transfers (order read as 1 when 0,
// capped at MAX_ORDER) the corrected step and its status leave on rsp_if.
// csr_if writes order (index 0) and power_mode (index 1) and is always ready;
// write it only while the block is idle. The first value of a point is only
// stored. The second runs one 96-step division on the shared divider, then a
// negation. Each later value runs four divisions and m multiplications on the
// shared multiplier, m = 2 with power_mode 0 and m = n-1 with power_mode 1 for
// value index n from 0. An emit state completes a point; the divider sets the pace.
// req_if.ready is high only while the sequencer is idle.
// The result sits in an output register; the next point's values are taken
// while it waits, and only a further result stalls until rsp_if drains.
// Reset clears the point state, sets order to 1 and power_mode to 0 and drops
// any pending result.
module higher_order_newton_step import hons_pkg::*; #(
   parameter int unsigned MAX_ORDER = 8
) (
   input  logic clock,
   input  logic reset,
   hons_req_if.sink   req_if,
   hons_rsp_if.source rsp_if,
   hons_csr_if.sink   csr_if
);
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DIV1  = 4'd1;
   localparam logic [3:0] S_NEG   = 4'd2;
   localparam logic [3:0] S_MULSP = 4'd3;
   localparam logic [3:0] S_POW   = 4'd4;
   localparam logic [3:0] S_MULD  = 4'd5;
   localparam logic [3:0] S_DIVF  = 4'd6;
   localparam logic [3:0] S_DIVI  = 4'd7;
   localparam logic [3:0] S_RECIP = 4'd8;
   localparam logic [3:0] S_SUB   = 4'd9;
   localparam logic [3:0] S_DIVS  = 4'd10;
   localparam logic [3:0] S_FIN   = 4'd11;
   localparam logic [3:0] S_EMIT  = 4'd12;

   localparam logic [3:0] MAX_ORD = 4'(MAX_ORDER);

   logic [3:0]    state_ff, state_in;
   logic          go_ff, go_in;
   logic [3:0]    order_ff, order_in;
   logic          mode_ff, mode_in;
   logic [QW-1:0] fv_ff, fv_in, cs_ff, cs_in, sp_ff, sp_in;
   logic [QW-1:0] d_ff, d_in, aux_ff, aux_in, t_ff, t_in, r_ff, r_in, s_ff, s_in;
   logic [31:0]   fact_ff, fact_in;
   logic [3:0]    vs_ff, vs_in, n_ff, n_in, cnt_ff, cnt_in;
   logic [1:0]    err_ff, err_in;
   logic          neg_ff, neg_in;
   logic          rv_ff, rv_in;
   logic [QW-1:0] rstep_ff, rstep_in;
   logic [1:0]    rstat_ff, rstat_in;

   logic            mul_start, mul_done;
   logic [QW-1:0]   mul_a, mul_b;
   logic [2*QW-1:0] mul_prod;
   logic            div_start, div_done, div_ovf;
   logic [QW+31:0]  div_num;
   logic [QW-1:0]   div_den, div_quo;

   logic [QW-1:0] opa, opb;
   logic [3:0]    eff;
   qres_type      mres, dres, tmp;
   logic [QW-1:0] iq;

   hons_mul u_mul (
      .clock (clock), .reset (reset), .start (mul_start),
      .a (mul_a), .b (mul_b), .done (mul_done), .prod (mul_prod)
   );

   hons_div u_div (
      .clock (clock), .reset (reset), .start (div_start),
      .num (div_num), .den (div_den), .done (div_done), .quo (div_quo), .ovf (div_ovf)
   );

   always_comb begin
      eff = order_ff;
      if (eff == 4'd0) begin
         eff = 4'd1;
      end
      if (eff > MAX_ORD) begin
         eff = MAX_ORD;
      end

      case (state_ff)
         S_DIV1:  begin opa = fv_ff;  opb = d_ff;  end
         S_DIVF:  begin opa = t_ff;   opb = fv_ff; end
         S_RECIP: begin opa = ONE_Q;  opb = cs_ff; end
         S_DIVS:  begin opa = ONE_Q;  opb = s_ff;  end
         S_MULSP: begin opa = sp_ff;  opb = cs_ff; end
         S_POW:   begin opa = aux_ff; opb = cs_ff; end
         S_MULD:  begin opa = aux_ff; opb = d_ff;  end
         default: begin opa = t_ff;   opb = '0;    end
      endcase

      mres = pack_q(neg_ff, mul_prod[95:32], mul_prod[127:96] != 32'd0);
      dres = pack_q(neg_ff, div_quo, div_ovf);
      iq   = neg_ff ? (~div_quo + 64'd1) : div_quo;
      tmp  = '0;

      mul_a   = mag(opa);
      mul_b   = mag(opb);
      div_num = {mag(opa), 32'd0};
      div_den = mag(opb);
      if (state_ff == S_DIVI) begin
         div_num = {32'd0, mag(t_ff)};
         div_den = (fact_ff == 32'd0) ? 64'd1 : {32'd0, fact_ff};
      end
      mul_start = 1'b0;
      div_start = 1'b0;

      state_in = state_ff;
      go_in    = go_ff;
      order_in = order_ff;
      mode_in  = mode_ff;
      fv_in    = fv_ff;
      cs_in    = cs_ff;
      sp_in    = sp_ff;
      d_in     = d_ff;
      aux_in   = aux_ff;
      t_in     = t_ff;
      r_in     = r_ff;
      s_in     = s_ff;
      fact_in  = fact_ff;
      vs_in    = vs_ff;
      n_in     = n_ff;
      cnt_in   = cnt_ff;
      err_in   = err_ff;
      neg_in   = neg_ff;
      rv_in    = rv_ff;
      rstep_in = rstep_ff;
      rstat_in = rstat_ff;

      if (rv_ff && rsp_if.ready) begin
         rv_in = 1'b0;
      end

      if (csr_if.valid) begin
         case (csr_if.index)
            REG_ORDER: order_in = csr_if.data[3:0];
            REG_MODE:  mode_in  = csr_if.data[0];
            default:   ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               d_in = req_if.derivative;
               n_in = vs_ff;
               if (vs_ff == 4'd0) begin
                  fv_in    = req_if.derivative;
                  state_in = S_FIN;
               end else if (vs_ff == 4'd1) begin
                  state_in = S_DIV1;
               end else begin
                  fact_in = fact_ff * {28'd0, vs_ff};
                  if (!mode_ff) begin
                     state_in = S_MULSP;
                  end else begin
                     aux_in   = cs_ff;
                     cnt_in   = vs_ff - 4'd2;
                     state_in = (vs_ff == 4'd2) ? S_MULD : S_POW;
                  end
               end
            end
         end
         S_MULSP, S_POW, S_MULD: begin
            if (!go_ff) begin
               mul_start = 1'b1;
               neg_in    = opa[QW-1] ^ opb[QW-1];
               go_in     = 1'b1;
            end else if (mul_done) begin
               go_in  = 1'b0;
               err_in = note(err_ff, mres.err);
               case (state_ff)
                  S_MULSP: begin
                     sp_in    = mres.val;
                     aux_in   = mres.val;
                     state_in = S_MULD;
                  end
                  S_POW: begin
                     aux_in = mres.val;
                     cnt_in = cnt_ff - 4'd1;
                     if (cnt_ff == 4'd1) begin
                        state_in = S_MULD;
                     end
                  end
                  default: begin
                     t_in     = mres.val;
                     state_in = S_DIVF;
                  end
               endcase
            end
         end
         S_DIV1, S_DIVF, S_RECIP, S_DIVS: begin
            if (!go_ff) begin
               if (opb == '0) begin
                  tmp.val = opa[QW-1] ? SIGN_Q : MAXP_Q;
                  tmp.err = ST_DIVZ;
               end else begin
                  div_start = 1'b1;
                  neg_in    = opa[QW-1] ^ opb[QW-1];
                  go_in     = 1'b1;
               end
            end else if (div_done) begin
               go_in = 1'b0;
               tmp   = dres;
            end
            if ((!go_ff && opb == '0) || (go_ff && div_done)) begin
               err_in = note(err_ff, tmp.err);
               case (state_ff)
                  S_DIV1: begin
                     t_in     = tmp.val;
                     state_in = S_NEG;
                  end
                  S_DIVF: begin
                     t_in     = tmp.val;
                     state_in = S_DIVI;
                  end
                  S_RECIP: begin
                     r_in     = tmp.val;
                     state_in = S_SUB;
                  end
                  default: begin
                     cs_in    = tmp.val;
                     state_in = S_FIN;
                  end
               endcase
            end
         end
         S_NEG: begin
            tmp      = q_neg(t_ff);
            cs_in    = tmp.val;
            err_in   = note(err_ff, tmp.err);
            state_in = S_FIN;
         end
         S_DIVI: begin
            if (!go_ff) begin
               div_start = 1'b1;
               neg_in    = t_ff[QW-1];
               go_in     = 1'b1;
            end else if (div_done) begin
               go_in    = 1'b0;
               t_in     = iq;
               state_in = S_RECIP;
            end
         end
         S_SUB: begin
            tmp      = q_sub(r_ff, t_ff);
            s_in     = tmp.val;
            err_in   = note(err_ff, tmp.err);
            state_in = S_DIVS;
         end
         S_FIN: begin
            if ({1'b0, n_ff} + 5'd1 >= {1'b0, eff} + 5'd1) begin
               state_in = S_EMIT;
            end else begin
               vs_in    = n_ff + 4'd1;
               state_in = S_IDLE;
            end
         end
         S_EMIT: begin
            if (!rv_ff || rsp_if.ready) begin
               rv_in    = 1'b1;
               rstep_in = cs_ff;
               rstat_in = err_ff;
               fv_in    = '0;
               cs_in    = '0;
               sp_in    = ONE_Q;
               fact_in  = 32'd1;
               vs_in    = 4'd0;
               err_in   = ST_OK;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      d_ff     <= d_in;
      n_ff     <= n_in;
      aux_ff   <= aux_in;
      t_ff     <= t_in;
      r_ff     <= r_in;
      s_ff     <= s_in;
      cnt_ff   <= cnt_in;
      neg_ff   <= neg_in;
      rstep_ff <= rstep_in;
      rstat_ff <= rstat_in;
      if (reset) begin
         state_ff <= S_IDLE;
         go_ff    <= 1'b0;
         order_ff <= 4'd1;
         mode_ff  <= 1'b0;
         fv_ff    <= '0;
         cs_ff    <= '0;
         sp_ff    <= ONE_Q;
         fact_ff  <= 32'd1;
         vs_ff    <= 4'd0;
         err_ff   <= ST_OK;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         go_ff    <= go_in;
         order_ff <= order_in;
         mode_ff  <= mode_in;
         fv_ff    <= fv_in;
         cs_ff    <= cs_in;
         sp_ff    <= sp_in;
         fact_ff  <= fact_in;
         vs_ff    <= vs_in;
         err_ff   <= err_in;
         rv_ff    <= rv_in;
      end
   end

   assign req_if.ready  = (state_ff == S_IDLE);
   assign csr_if.ready  = 1'b1;
   assign rsp_if.valid  = rv_ff;
   assign rsp_if.step   = rstep_ff;
   assign rsp_if.status = rstat_ff;
endmodule

/* tb/tb.sv */
module tb;
   import hons_pkg::*;

   localparam int unsigned ORDER_CAP = 8;
   localparam longint unsigned CYCLE_LIMIT = 5_000_000;

   class newton_scoreboard;
      logic [3:0]    order_reg;
      logic          mode_reg;
      logic [QW-1:0] f0;
      logic [QW-1:0] cur_step;
      logic [QW-1:0] prod;
      logic [31:0]   fact;
      int unsigned   seen;
      logic [1:0]    err;
      logic [QW+1:0] steps_due[$];
      int            mismatches;

      function new();
         order_reg  = 4'd1;
         mode_reg   = 1'b0;
         mismatches = 0;
         clear_point();
      endfunction

      function void clear_point();
         f0       = '0;
         cur_step = '0;
         prod     = ONE_Q;
         fact     = 32'd1;
         seen     = 0;
         err      = ST_OK;
      endfunction

      function void flag(logic [1:0] code);
         if (err == ST_OK) err = code;
      endfunction

      function logic [QW-1:0] abs_q(logic [QW-1:0] v);
         return v[QW-1] ? -v : v;
      endfunction

      function logic [QW-1:0] saturate(bit neg, logic [QW-1:0] m, bit ovf);
         logic [QW-1:0] lim;
         lim = neg ? SIGN_Q : MAXP_Q;
         if (ovf || m > lim) begin
            flag(ST_OVF);
            m = lim;
         end
         return neg ? -m : m;
      endfunction

      function logic [QW-1:0] mul_q(logic [QW-1:0] a, logic [QW-1:0] b);
         logic [127:0] p;
         p = {64'd0, abs_q(a)} * {64'd0, abs_q(b)};
         return saturate(a[QW-1] ^ b[QW-1], p[95:32], |p[127:96]);
      endfunction

      function logic [QW-1:0] div_q(logic [QW-1:0] a, logic [QW-1:0] b);
         logic [95:0] q;
         if (b == '0) begin
            flag(ST_DIVZ);
            return a[QW-1] ? SIGN_Q : MAXP_Q;
         end
         q = {abs_q(a), 32'd0} / {32'd0, abs_q(b)};
         return saturate(a[QW-1] ^ b[QW-1], q[63:0], |q[95:64]);
      endfunction

      function logic [QW-1:0] neg_q(logic [QW-1:0] v);
         if (v == SIGN_Q) begin
            flag(ST_OVF);
            return MAXP_Q;
         end
         return -v;
      endfunction

      function logic [QW-1:0] sub_q(logic [QW-1:0] a, logic [QW-1:0] b);
         logic [QW-1:0] r;
         r = a - b;
         if (a[QW-1] != b[QW-1] && r[QW-1] != a[QW-1]) begin
            flag(ST_OVF);
            return a[QW-1] ? SIGN_Q : MAXP_Q;
         end
         return r;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == REG_ORDER) order_reg = data[3:0];
         else if (idx == REG_MODE) mode_reg = data[0];
      endfunction

      function void note_input(logic [QW-1:0] d);
         int unsigned   eff;
         int unsigned   n;
         int unsigned   k;
         logic [QW-1:0] aux;
         logic [QW-1:0] t;
         logic [QW-1:0] m;
         eff = order_reg;
         if (eff < 1) eff = 1;
         if (eff > ORDER_CAP) eff = ORDER_CAP;
         n = seen;
         if (n == 0) begin
            f0 = d;
         end else if (n == 1) begin
            cur_step = neg_q(div_q(f0, d));
         end else begin
            k = n - 1;
            fact = fact * (k + 1);
            if (mode_reg == 1'b0) begin
               prod = mul_q(prod, cur_step);
               aux  = prod;
            end else begin
               aux = cur_step;
               for (int i = 1; i < k; i++) aux = mul_q(aux, cur_step);
            end
            t = mul_q(aux, d);
            t = div_q(t, f0);
            m = abs_q(t) / {32'd0, (fact == 0 ? 32'd1 : fact)};
            t = t[QW-1] ? -m : m;
            cur_step = div_q(ONE_Q, sub_q(div_q(ONE_Q, cur_step), t));
         end
         seen = (n + 1) & 15;
         if (n + 1 >= eff + 1) begin
            steps_due.push_back({cur_step, err});
            clear_point();
         end
      endfunction

      function void check(logic [QW-1:0] step, logic [1:0] status);
         logic [QW+1:0] want;
         if (steps_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("tb: unexpected step %h status %0d", step, status);
            return;
         end
         want = steps_due.pop_front();
         if (step !== want[QW+1:2] || status !== want[1:0]) begin
            mismatches++;
            if (mismatches <= 10)
               $display("tb: step %h status %0d, wanted step %h status %0d",
                        step, status, want[QW+1:2], want[1:0]);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   quiet;
   longint unsigned cycles;
   newton_scoreboard sb;

   hons_req_if req_if ();
   hons_rsp_if rsp_if ();
   hons_csr_if csr_if ();

   higher_order_newton_step #(.MAX_ORDER(ORDER_CAP)) uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if.sink),
      .rsp_if (rsp_if.source),
      .csr_if (csr_if.sink)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) sb.check(rsp_if.step, rsp_if.status);
   end

   // stall the result side in bursts
   initial begin
      rsp_if.ready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
      end
   end

   task automatic send_value(logic [QW-1:0] d);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.derivative <= d;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sb.note_input(d);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= data;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      sb.write_reg(idx, data);
      csr_if.valid <= 1'b0;
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      while (sb.steps_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic [QW-1:0] pick_value();
      logic signed [QW-1:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 11))
         0, 1: return v;
         2: return '0;
         3: return SIGN_Q;
         4: return MAXP_Q;
         5: return $urandom_range(0, 1) ? ONE_Q : -ONE_Q;
         default: return v >>> $urandom_range(22, 62);
      endcase
   endfunction

   task automatic run_phase(logic [3:0] ord, logic mode, int unsigned items);
      int unsigned eff;
      write_csr(REG_ORDER, {4'($urandom_range(0, 15)), ord});
      write_csr(REG_MODE, {7'($urandom_range(0, 127)), mode});
      eff = (ord == 0) ? 1 : (ord > ORDER_CAP ? ORDER_CAP : ord);
      for (int p = 0; p < items / (eff + 1); p++)
         for (int i = 0; i <= eff; i++) send_value(pick_value());
      drain();
   endtask

   initial begin
      logic [3:0] orders[10] = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd5, 4'd2, 4'd9, 4'd8, 4'd4};
      sb     = new();
      cycles = 0;
      quiet  = 1'b0;
      reset  = 1'b1;
      req_if.valid      = 1'b0;
      req_if.derivative = '0;
      csr_if.valid = 1'b0;
      csr_if.index = REG_ORDER;
      csr_if.data  = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // negate overflow, zero divisors, plain step, saturated quotient
      send_value(SIGN_Q);  send_value(ONE_Q);
      send_value(ONE_Q);   send_value('0);
      send_value('0);      send_value('0);
      send_value(-(ONE_Q * 3)); send_value(ONE_Q * 2);
      send_value(MAXP_Q);  send_value(64'd1);
      drain();
      write_csr(REG_ORDER, 8'd3);
      write_csr(REG_MODE, 8'd1);
      send_value(ONE_Q);   send_value(ONE_Q * 2); send_value(-ONE_Q); send_value(MAXP_Q);
      send_value('0);      send_value(ONE_Q);     send_value(ONE_Q);  send_value(SIGN_Q);
      drain();
      write_csr(REG_MODE, 8'd0);
      send_value(ONE_Q * 5); send_value(-ONE_Q); send_value(ONE_Q >> 4); send_value('0);
      drain();

      foreach (orders[i]) begin
         if (i == 9) quiet = 1'b1;
         run_phase(orders[i], i[0], 140);
      end

      if (sb.mismatches == 0 && sb.steps_due.size() == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end
endmodule

/* files.f */
design/hons_pkg.sv
design/hons_if.sv
design/hons_mul.sv
design/hons_div.sv
design/higher_order_newton_step.sv
tb/tb.sv
